>>> rtl/ps2_mouse_packet_cursor_macros.svh
// Assertion macros used by the checker file of the PS/2 cursor block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PS2_MOUSE_PACKET_CURSOR_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define PS2MPC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PS2MPC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/ps2mpc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor block.
// No dependencies; the interfaces, the top level and the checker refer to it by scoped name.
`default_nettype none

package ps2mpc_pkg;

  localparam int POS_BITS_DEF = 10;
  localparam int CFG_W        = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_POS_W    = 10;
  localparam int DELTA_W      = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y  = 2'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_X_LIMIT = 10'd314;
  localparam logic [CFG_W-1:0] RST_Y_LIMIT = 10'd234;
  localparam logic [CFG_W-1:0] RST_HOME_X  = 10'd160;
  localparam logic [CFG_W-1:0] RST_HOME_Y  = 10'd120;

  // Header byte bit positions.
  localparam int HDR_LEFT  = 0;
  localparam int HDR_RIGHT = 1;
  localparam int HDR_MARK  = 3;
  localparam int HDR_XSIGN = 4;
  localparam int HDR_YSIGN = 5;
  localparam int HDR_XOVF  = 6;
  localparam int HDR_YOVF  = 7;

  // Position of the next byte within a packet.
  typedef enum logic [1:0] {
    IDX_HEADER = 2'd0,
    IDX_X      = 2'd1,
    IDX_Y      = 2'd2
  } byte_idx_t;

endpackage

`default_nettype wire

>>> rtl/ps2mpc_ifs.sv
// Valid/ready channel interfaces for the PS/2 cursor block: the received byte
// channel and the cursor result channel. Uses ps2mpc_pkg for field widths.
`default_nettype none

interface ps2mpc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mpc_res_if;
  logic                                    valid;
  logic                                    ready;
  logic        [ps2mpc_pkg::OUT_POS_W-1:0] cursor_x;
  logic        [ps2mpc_pkg::OUT_POS_W-1:0] cursor_y;
  logic                                    left_button;
  logic                                    right_button;
  logic signed [ps2mpc_pkg::DELTA_W-1:0]   delta_x;
  logic signed [ps2mpc_pkg::DELTA_W-1:0]   delta_y;

  modport source (output valid, output cursor_x, output cursor_y, output left_button,
                  output right_button, output delta_x, output delta_y, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_button,
                  input right_button, input delta_x, input delta_y, output ready);
endinterface

`default_nettype wire

>>> rtl/ps2mpc_axis_move.sv
// One cursor axis: adds a signed step to the position and clamps to [0, limit].
// Depends on nothing but its parameter; instantiated twice by the top level.
`default_nettype none

module ps2mpc_axis_move #(
  parameter int POS_BITS = 10
) (
  input  wire logic        [POS_BITS-1:0] pos,
  input  wire logic signed [9:0]          step,
  input  wire logic        [POS_BITS-1:0] limit,
  output logic             [POS_BITS-1:0] new_pos
);

  localparam int SW = POS_BITS + 2;

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] hi;

  always_comb begin
    sum = $signed({2'b00, pos}) + SW'(step);
    hi  = $signed({2'b00, limit});
    priority if (sum < 0) begin
      new_pos = '0;
    end else if (sum > hi) begin
      new_pos = limit;
    end else begin
      new_pos = sum[POS_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ps2_mouse_packet_cursor.sv
// PS/2 mouse packet decoder with clamped cursor: one result word per three-byte packet.
// The third packet byte passes the input register stage, then sets the result register valid.
// Throughput: one byte per cycle; the input stalls only while a result waits unread.
// Reset (rst_n low, synchronous): input not ready, parser waits for a header, registers
// take their defaults, and the cursor sits at the default home position.
`default_nettype none

module ps2_mouse_packet_cursor #(
  parameter int POS_BITS = ps2mpc_pkg::POS_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ps2mpc_rx_if.sink                             in_ch,
  ps2mpc_res_if.source                          out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [ps2mpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ps2mpc_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CW = ps2mpc_pkg::CFG_W;
  localparam int OW = ps2mpc_pkg::OUT_POS_W;
  localparam int DW = ps2mpc_pkg::DELTA_W;

  localparam logic [POS_BITS+CW-1:0] HOME_X_EXT = {{POS_BITS{1'b0}}, ps2mpc_pkg::RST_HOME_X};
  localparam logic [POS_BITS+CW-1:0] HOME_Y_EXT = {{POS_BITS{1'b0}}, ps2mpc_pkg::RST_HOME_Y};
  localparam logic [POS_BITS-1:0]    POS_RST_X  = HOME_X_EXT[POS_BITS-1:0];
  localparam logic [POS_BITS-1:0]    POS_RST_Y  = HOME_Y_EXT[POS_BITS-1:0];

  // Configuration registers.
  logic [CW-1:0] x_limit_r, y_limit_r;

  // Input register stage.
  logic       s1_v_r;
  logic [7:0] s1_byte_r;

  // Parser and cursor state.
  ps2mpc_pkg::byte_idx_t idx_r, idx_nxt;
  logic [7:0]            hdr_r, hdr_nxt;
  logic [7:0]            xb_r, xb_nxt;
  logic [POS_BITS-1:0]   pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;

  // Result register.
  logic                 out_v_r, out_v_nxt;
  logic [OW-1:0]        cur_x_r, cur_y_r;
  logic                 left_r, right_r;
  logic signed [DW-1:0] dx_r, dy_r;

  logic                 adv;
  logic                 res_fire;
  logic signed [DW-1:0] dx, dy;
  logic signed [9:0]    step_x, step_y;
  logic [POS_BITS-1:0]  lim_x, lim_y, mv_x, mv_y;
  logic [POS_BITS+CW-1:0] lim_x_ext, lim_y_ext;
  logic [POS_BITS+OW-1:0] pos_x_ext, pos_y_ext;

  // The staged byte moves on when the result register can take whatever it makes.
  assign adv         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = rst_n && (!s1_v_r || adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= ps2mpc_pkg::RST_X_LIMIT;
      y_limit_r <= ps2mpc_pkg::RST_Y_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ps2mpc_pkg::CFG_X_LIMIT: x_limit_r <= cfg_wdata;
        ps2mpc_pkg::CFG_Y_LIMIT: y_limit_r <= cfg_wdata;
        // The cursor takes the default home position at reset and the home indexes have
        // no registers, so a home write never shows.
        ps2mpc_pkg::CFG_HOME_X, ps2mpc_pkg::CFG_HOME_Y: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  always_comb begin
    lim_x_ext = {{POS_BITS{1'b0}}, x_limit_r};
    lim_y_ext = {{POS_BITS{1'b0}}, y_limit_r};
    lim_x     = lim_x_ext[POS_BITS-1:0];
    lim_y     = lim_y_ext[POS_BITS-1:0];
    dx        = hdr_r[ps2mpc_pkg::HDR_XOVF] ? '0 : $signed({hdr_r[ps2mpc_pkg::HDR_XSIGN], xb_r});
    dy        = hdr_r[ps2mpc_pkg::HDR_YOVF] ? '0
                : $signed({hdr_r[ps2mpc_pkg::HDR_YSIGN], s1_byte_r});
    step_x    = 10'(dx);
    // Screen y grows downward, so upward mouse motion decreases the cursor y.
    step_y    = -(10'(dy));
  end

  ps2mpc_axis_move #(.POS_BITS(POS_BITS)) u_move_x (
    .pos     (pos_x_r),
    .step    (step_x),
    .limit   (lim_x),
    .new_pos (mv_x)
  );

  ps2mpc_axis_move #(.POS_BITS(POS_BITS)) u_move_y (
    .pos     (pos_y_r),
    .step    (step_y),
    .limit   (lim_y),
    .new_pos (mv_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= ps2mpc_pkg::IDX_HEADER;
      hdr_r   <= '0;
      xb_r    <= '0;
      pos_x_r <= POS_RST_X;
      pos_y_r <= POS_RST_Y;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      hdr_r   <= hdr_nxt;
      xb_r    <= xb_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    hdr_nxt   = hdr_r;
    xb_nxt    = xb_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    res_fire  = 1'b0;
    if (adv) begin
      unique case (idx_r)
        ps2mpc_pkg::IDX_X: begin
          xb_nxt  = s1_byte_r;
          idx_nxt = ps2mpc_pkg::IDX_Y;
        end
        ps2mpc_pkg::IDX_Y: begin
          pos_x_nxt = mv_x;
          pos_y_nxt = mv_y;
          res_fire  = 1'b1;
          idx_nxt   = ps2mpc_pkg::IDX_HEADER;
        end
        default: begin
          // A header without its marker bit is dropped to regain packet alignment.
          if (s1_byte_r[ps2mpc_pkg::HDR_MARK]) begin
            hdr_nxt = s1_byte_r;
            idx_nxt = ps2mpc_pkg::IDX_X;
          end else begin
            idx_nxt = ps2mpc_pkg::IDX_HEADER;
          end
        end
      endcase
    end
    if (res_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_comb begin
    pos_x_ext = {{OW{1'b0}}, mv_x};
    pos_y_ext = {{OW{1'b0}}, mv_y};
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      cur_x_r <= pos_x_ext[OW-1:0];
      cur_y_r <= pos_y_ext[OW-1:0];
      left_r  <= hdr_r[ps2mpc_pkg::HDR_LEFT];
      right_r <= hdr_r[ps2mpc_pkg::HDR_RIGHT];
      dx_r    <= dx;
      dy_r    <= dy;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.cursor_x     = cur_x_r;
  assign out_ch.cursor_y     = cur_y_r;
  assign out_ch.left_button  = left_r;
  assign out_ch.right_button = right_r;
  assign out_ch.delta_x      = dx_r;
  assign out_ch.delta_y      = dy_r;

endmodule

`default_nettype wire

>>> rtl/ps2mpc_checker.sv
// Port-level checker for ps2_mouse_packet_cursor, attached by the bind below.
// Uses ps2mpc_pkg and the assertion macros in ps2_mouse_packet_cursor_macros.svh.
`default_nettype none
`include "ps2_mouse_packet_cursor_macros.svh"

module ps2mpc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [ps2mpc_pkg::OUT_POS_W-1:0]  cursor_x,
  input wire logic [ps2mpc_pkg::OUT_POS_W-1:0]  cursor_y,
  input wire logic [ps2mpc_pkg::DELTA_W-1:0]    delta_x,
  input wire logic                              cfg_we,
  input wire logic [ps2mpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [ps2mpc_pkg::CFG_W-1:0]      cfg_wdata
);

  // Shadow copies of the limit registers, tracked from the write port.
  logic [ps2mpc_pkg::CFG_W-1:0] x_lim_r, y_lim_r;
  logic                         out_stall;

  assign out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lim_r <= ps2mpc_pkg::RST_X_LIMIT;
      y_lim_r <= ps2mpc_pkg::RST_Y_LIMIT;
    end else if (cfg_we) begin
      if (cfg_index == ps2mpc_pkg::CFG_X_LIMIT) begin
        x_lim_r <= cfg_wdata;
      end
      if (cfg_index == ps2mpc_pkg::CFG_Y_LIMIT) begin
        y_lim_r <= cfg_wdata;
      end
    end
  end

  // The input only stalls behind a result word that is waiting to be taken.
  `PS2MPC_ASSERT_IMPL(a_stall_cause, !in_ready, out_stall, "input stalled with output free")

  `PS2MPC_ASSERT_IMPL(a_x_clamped, out_valid, cursor_x <= x_lim_r, "cursor x above x limit")

  `PS2MPC_ASSERT_IMPL(a_y_clamped, out_valid, cursor_y <= y_lim_r, "cursor y above y limit")

  `PS2MPC_ASSERT_NEXT(a_out_hold, out_stall,
                      out_valid && $stable(cursor_x) && $stable(cursor_y) && $stable(delta_x),
                      "stalled result word changed")

endmodule

bind ps2_mouse_packet_cursor ps2mpc_checker u_ps2mpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cursor_x  (out_ch.cursor_x),
  .cursor_y  (out_ch.cursor_y),
  .delta_x   (out_ch.delta_x),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

`default_nettype wire
